// ===== hw/rtl/ttce_pkg.sv =====
// Shared types, constants and helpers for the text terminal character engine.
package ttce_pkg;

    localparam int COLUMNS  = 80;
    localparam int ROWS     = 25;
    localparam int TAB_STOP = 8;
    localparam int CELLS    = ROWS * COLUMNS;

    localparam int ROW_W  = 5;
    localparam int COL_W  = 7;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int LOC_W  = 11;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [7:0] BLANK_CHAR  = 8'h20;
    localparam logic [7:0] RESET_COLOR = 8'h0F;
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] PRINT_LO    = 8'h20;
    localparam logic [7:0] PRINT_HI    = 8'h7F;

    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_TAB,
        OP_PRINT,
        OP_READ,
        OP_READ_OOR
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_RUN,
        ST_READ,
        ST_BLANK
    } back_state_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       code;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } item_t;

    // Map a screen row onto the circular row store.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] sum;
        sum = {1'b0, r} + {1'b0, top};
        if (sum >= (ROW_W+1)'(ROWS)) begin
            sum = sum - (ROW_W+1)'(ROWS);
        end
        return sum[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        logic [ADDR_W-1:0] base;
        base = ADDR_W'(prow) * ADDR_W'(COLUMNS);
        return base + ADDR_W'(col);
    endfunction

endpackage

// ===== hw/rtl/ttce_front.sv =====
// Input stage: accepts items, decodes them into operations, holds one for the queue.
module ttce_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [7:0]                  s_char_code,
    input  logic [ttce_pkg::ROW_W-1:0]  s_read_row,
    input  logic [ttce_pkg::COL_W-1:0]  s_read_col,
    input  logic                        clearing,
    output logic                        q_valid,
    input  logic                        q_ready,
    output ttce_pkg::item_t             q_item
);

    logic            hold_valid_reg, hold_valid_next;
    ttce_pkg::item_t hold_item_reg, hold_item_next;
    ttce_pkg::item_t decoded;
    logic            s_accept;

    always_comb begin
        decoded.code = s_char_code;
        decoded.row  = s_read_row;
        decoded.col  = s_read_col;
        if (s_func == ttce_pkg::FUNC_READ) begin
            if ((s_read_row < ttce_pkg::ROW_W'(ttce_pkg::ROWS)) &&
                (s_read_col < ttce_pkg::COL_W'(ttce_pkg::COLUMNS))) begin
                decoded.op = ttce_pkg::OP_READ;
            end else begin
                decoded.op = ttce_pkg::OP_READ_OOR;
            end
        end else if (s_char_code == ttce_pkg::CH_CR) begin
            decoded.op = ttce_pkg::OP_CR;
        end else if (s_char_code == ttce_pkg::CH_LF) begin
            decoded.op = ttce_pkg::OP_LF;
        end else if (s_char_code == ttce_pkg::CH_BS) begin
            decoded.op = ttce_pkg::OP_BS;
        end else if (s_char_code == ttce_pkg::CH_TAB) begin
            decoded.op = ttce_pkg::OP_TAB;
        end else if ((s_char_code >= ttce_pkg::PRINT_LO) &&
                     (s_char_code <= ttce_pkg::PRINT_HI)) begin
            decoded.op = ttce_pkg::OP_PRINT;
        end else begin
            decoded.op = ttce_pkg::OP_NOP;
        end
    end

    // Hold off new items while the screen store is being cleared.
    assign s_ready  = !clearing && (!hold_valid_reg || q_ready);
    assign s_accept = s_valid && s_ready;
    assign q_valid  = hold_valid_reg;
    assign q_item   = hold_item_reg;

    always_comb begin
        hold_valid_next = hold_valid_reg;
        hold_item_next  = hold_item_reg;
        if (s_accept) begin
            hold_valid_next = 1'b1;
            hold_item_next  = decoded;
        end else if (q_ready) begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
        hold_item_reg <= hold_item_next;
    end

endmodule

// ===== hw/rtl/ttce_fifo.sv =====
// Short queue of decoded items between the front and back parts.
module ttce_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  ttce_pkg::item_t in_item,
    output logic            out_valid,
    input  logic            out_pop,
    output ttce_pkg::item_t out_item
);

    ttce_pkg::item_t                 entry_reg [ttce_pkg::QDEPTH];
    logic [ttce_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [ttce_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [ttce_pkg::QCNT_W-1:0]     count_reg, count_next;
    logic                            push, pop;

    assign in_ready  = count_reg < ttce_pkg::QCNT_W'(ttce_pkg::QDEPTH);
    assign out_valid = count_reg != '0;
    assign out_item  = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == ttce_pkg::QPTR_W'(ttce_pkg::QDEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == ttce_pkg::QPTR_W'(ttce_pkg::QDEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// ===== hw/rtl/ttce_back.sv =====
// Execution part: cursor, circular screen store, scroll blanking and result register.
module ttce_back (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    input  logic [7:0]                   cfg_data,
    input  logic                         q_valid,
    output logic                         q_pop,
    input  ttce_pkg::item_t              q_item,
    output logic                         clearing,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [ttce_pkg::ROW_W-1:0]   m_cursor_row,
    output logic [ttce_pkg::COL_W-1:0]   m_cursor_col,
    output logic [ttce_pkg::LOC_W-1:0]   m_cursor_location,
    output logic [7:0]                   m_cell_char,
    output logic [7:0]                   m_cell_color
);

    localparam int ROW_W  = ttce_pkg::ROW_W;
    localparam int COL_W  = ttce_pkg::COL_W;
    localparam int ADDR_W = ttce_pkg::ADDR_W;
    localparam int LOC_W  = ttce_pkg::LOC_W;

    ttce_pkg::back_state_t state_reg, state_next;

    logic [7:0]        text_color_reg;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  top_reg, top_next;
    logic [ADDR_W-1:0] clr_cnt_reg, clr_cnt_next;
    logic [ROW_W-1:0]  blank_row_reg, blank_row_next;
    logic [COL_W-1:0]  blank_col_reg, blank_col_next;
    logic [7:0]        blank_color_reg, blank_color_next;

    logic              m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]  m_row_reg, m_row_next;
    logic [COL_W-1:0]  m_col_reg, m_col_next;
    logic [LOC_W-1:0]  m_loc_reg, m_loc_next;
    logic [7:0]        m_char_reg, m_char_next;
    logic [7:0]        m_color_reg, m_color_next;

    logic [15:0]       mem [ttce_pkg::CELLS];
    logic [15:0]       rd_data_reg;
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [15:0]       wr_data;

    logic              out_free;
    logic [COL_W:0]    col_w;
    logic [ROW_W:0]    row_w;
    logic [COL_W:0]    tab_col;
    logic              scroll;
    logic [LOC_W-1:0]  cur_loc;

    assign out_free = !m_valid_reg || m_ready;
    assign clearing = (state_reg == ttce_pkg::ST_CLEAR);
    assign cur_loc  = LOC_W'(cur_row_reg) * LOC_W'(ttce_pkg::COLUMNS) + LOC_W'(cur_col_reg);
    assign tab_col  = ({1'b0, cur_col_reg} / (COL_W+1)'(ttce_pkg::TAB_STOP) + 1'b1) *
                      (COL_W+1)'(ttce_pkg::TAB_STOP);

    // Cursor motion for a put item, including wrap and scroll.
    always_comb begin
        col_w = {1'b0, cur_col_reg};
        row_w = {1'b0, cur_row_reg};
        case (q_item.op)
            ttce_pkg::OP_CR: begin
                col_w = '0;
            end
            ttce_pkg::OP_LF: begin
                col_w = '0;
                row_w = row_w + 1'b1;
            end
            ttce_pkg::OP_BS: begin
                if (cur_col_reg != '0) begin
                    col_w = col_w - 1'b1;
                end
            end
            ttce_pkg::OP_TAB: begin
                col_w = tab_col;
            end
            ttce_pkg::OP_PRINT: begin
                col_w = col_w + 1'b1;
            end
            default: begin
            end
        endcase
        if (col_w >= (COL_W+1)'(ttce_pkg::COLUMNS)) begin
            col_w = '0;
            row_w = row_w + 1'b1;
        end
        scroll = 1'b0;
        if (row_w >= (ROW_W+1)'(ttce_pkg::ROWS)) begin
            scroll = 1'b1;
            row_w  = (ROW_W+1)'(ttce_pkg::ROWS - 1);
        end
    end

    always_comb begin
        state_next       = state_reg;
        cur_row_next     = cur_row_reg;
        cur_col_next     = cur_col_reg;
        top_next         = top_reg;
        clr_cnt_next     = clr_cnt_reg;
        blank_row_next   = blank_row_reg;
        blank_col_next   = blank_col_reg;
        blank_color_next = blank_color_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_row_next       = m_row_reg;
        m_col_next       = m_col_reg;
        m_loc_next       = m_loc_reg;
        m_char_next      = m_char_reg;
        m_color_next     = m_color_reg;
        q_pop            = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = clr_cnt_reg;
        wr_data          = {ttce_pkg::RESET_COLOR, ttce_pkg::BLANK_CHAR};
        rd_en            = 1'b0;
        rd_addr          = ttce_pkg::cell_addr(ttce_pkg::phys_row(q_item.row, top_reg),
                                               q_item.col);
        case (state_reg)
            ttce_pkg::ST_CLEAR: begin
                wr_en = 1'b1;
                if (clr_cnt_reg == ADDR_W'(ttce_pkg::CELLS - 1)) begin
                    state_next = ttce_pkg::ST_RUN;
                end else begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            ttce_pkg::ST_RUN: begin
                if (q_valid && out_free) begin
                    q_pop = 1'b1;
                    if (q_item.op == ttce_pkg::OP_READ) begin
                        rd_en      = 1'b1;
                        state_next = ttce_pkg::ST_READ;
                    end else if (q_item.op == ttce_pkg::OP_READ_OOR) begin
                        m_valid_next = 1'b1;
                        m_row_next   = cur_row_reg;
                        m_col_next   = cur_col_reg;
                        m_loc_next   = cur_loc;
                        m_char_next  = '0;
                        m_color_next = '0;
                    end else begin
                        if (q_item.op == ttce_pkg::OP_PRINT) begin
                            wr_en   = 1'b1;
                            wr_addr = ttce_pkg::cell_addr(
                                          ttce_pkg::phys_row(cur_row_reg, top_reg),
                                          cur_col_reg);
                            wr_data = {text_color_reg, q_item.code};
                        end
                        cur_row_next = row_w[ROW_W-1:0];
                        cur_col_next = col_w[COL_W-1:0];
                        m_valid_next = 1'b1;
                        m_row_next   = row_w[ROW_W-1:0];
                        m_col_next   = col_w[COL_W-1:0];
                        m_loc_next   = LOC_W'(row_w) * LOC_W'(ttce_pkg::COLUMNS) +
                                       LOC_W'(col_w);
                        m_char_next  = '0;
                        m_color_next = '0;
                        if (scroll) begin
                            // Old top row turns into the new bottom row; blank it.
                            top_next         = ttce_pkg::phys_row(ROW_W'(1), top_reg);
                            blank_row_next   = top_reg;
                            blank_col_next   = '0;
                            blank_color_next = text_color_reg;
                            state_next       = ttce_pkg::ST_BLANK;
                        end
                    end
                end
            end
            ttce_pkg::ST_READ: begin
                m_valid_next = 1'b1;
                m_row_next   = cur_row_reg;
                m_col_next   = cur_col_reg;
                m_loc_next   = cur_loc;
                m_char_next  = rd_data_reg[7:0];
                m_color_next = rd_data_reg[15:8];
                state_next   = ttce_pkg::ST_RUN;
            end
            ttce_pkg::ST_BLANK: begin
                wr_en   = 1'b1;
                wr_addr = ttce_pkg::cell_addr(blank_row_reg, blank_col_reg);
                wr_data = {blank_color_reg, ttce_pkg::BLANK_CHAR};
                if (blank_col_reg == COL_W'(ttce_pkg::COLUMNS - 1)) begin
                    state_next = ttce_pkg::ST_RUN;
                end else begin
                    blank_col_next = blank_col_reg + 1'b1;
                end
            end
            default: begin
                state_next = ttce_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ttce_pkg::ST_CLEAR;
            text_color_reg <= ttce_pkg::RESET_COLOR;
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            top_reg        <= '0;
            clr_cnt_reg    <= '0;
            blank_col_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg     <= state_next;
            if (cfg_valid) begin
                text_color_reg <= cfg_data;
            end
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            clr_cnt_reg   <= clr_cnt_next;
            blank_col_reg <= blank_col_next;
            m_valid_reg   <= m_valid_next;
        end
        blank_row_reg   <= blank_row_next;
        blank_color_reg <= blank_color_next;
        m_row_reg       <= m_row_next;
        m_col_reg       <= m_col_next;
        m_loc_reg       <= m_loc_next;
        m_char_reg      <= m_char_next;
        m_color_reg     <= m_color_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_cursor_row      = m_row_reg;
    assign m_cursor_col      = m_col_reg;
    assign m_cursor_location = m_loc_reg;
    assign m_cell_char       = m_char_reg;
    assign m_cell_color      = m_color_reg;

endmodule

// ===== hw/rtl/text_terminal_char_engine_unit.sv =====
// Top level of the text terminal character engine.
// Input channel s_*: func 0 puts char_code at the cursor (CR, LF, backspace,
// tab, printable 0x20..0x7F; other bytes leave the cursor as is), func 1 reads
// the cell at read_row/read_col (0/0 returned when out of range).
// Result channel m_*: one item per input item, in order, carrying the cursor
// after the item and, for reads, the cell character and attribute.
// Config channel cfg_*: writes text_color, the attribute for written cells and
// for the row blanked on a scroll; always ready.
// A put passes the decode register and the queue into the result register,
// a read also the registered screen-store read. Throughput: one put per
// cycle while m_ready is high and no scroll is under way; a read holds the
// next item until its cell data is back from the single read port; a put
// that scrolls stalls the queue while the write port blanks the new bottom
// row (rows are kept as a circular store). Reset: the screen store is swept
// to blank cells with attribute 0x0F, one cell a cycle, during which s_ready
// stays low. A stalled m_ready holds the result; the two-entry queue and
// decode register keep taking items until they fill, then s_ready drops.
module text_terminal_char_engine_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [7:0]                  cfg_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic                        s_func,
    input  logic [7:0]                  s_char_code,
    input  logic [ttce_pkg::ROW_W-1:0]  s_read_row,
    input  logic [ttce_pkg::COL_W-1:0]  s_read_col,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ttce_pkg::ROW_W-1:0]  m_cursor_row,
    output logic [ttce_pkg::COL_W-1:0]  m_cursor_col,
    output logic [ttce_pkg::LOC_W-1:0]  m_cursor_location,
    output logic [7:0]                  m_cell_char,
    output logic [7:0]                  m_cell_color
);

    logic            clearing;
    logic            fq_valid, fq_ready;
    ttce_pkg::item_t fq_item;
    logic            bq_valid, bq_pop;
    ttce_pkg::item_t bq_item;

    assign cfg_ready = 1'b1;

    ttce_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_char_code (s_char_code),
        .s_read_row  (s_read_row),
        .s_read_col  (s_read_col),
        .clearing    (clearing),
        .q_valid     (fq_valid),
        .q_ready     (fq_ready),
        .q_item      (fq_item)
    );

    ttce_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (bq_valid),
        .out_pop   (bq_pop),
        .out_item  (bq_item)
    );

    ttce_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_data          (cfg_data),
        .q_valid           (bq_valid),
        .q_pop             (bq_pop),
        .q_item            (bq_item),
        .clearing          (clearing),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_col      (m_cursor_col),
        .m_cursor_location (m_cursor_location),
        .m_cell_char       (m_cell_char),
        .m_cell_color      (m_cell_color)
    );

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the text terminal character engine.
module testbench;
    import ttce_pkg::*;

    localparam int LIMIT_CYCLES  = 1000000;
    localparam int SETTLE_CYCLES = 120;
    localparam int PHASES        = 5;
    localparam int PHASE_ITEMS   = 350;
    localparam int MAX_PRINTS    = 40;

    typedef struct {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [LOC_W-1:0] loc;
        logic [7:0]       ch;
        logic [7:0]       attr;
    } cursor_report_t;

    class screen_scoreboard;
        logic [15:0]    cells [CELLS];
        int unsigned    row;
        int unsigned    col;
        logic [7:0]     color;
        cursor_report_t awaited [$];
        int             errors;
        int             checked;
        int             puts;
        int             reads;
        int             scrolls;

        function new();
            for (int k = 0; k < CELLS; k++) begin
                cells[k] = {RESET_COLOR, BLANK_CHAR};
            end
            row     = 0;
            col     = 0;
            color   = RESET_COLOR;
            errors  = 0;
            checked = 0;
            puts    = 0;
            reads   = 0;
            scrolls = 0;
        endfunction

        function void scroll_screen();
            for (int k = 0; k < CELLS - COLUMNS; k++) begin
                cells[k] = cells[k + COLUMNS];
            end
            for (int k = CELLS - COLUMNS; k < CELLS; k++) begin
                cells[k] = {color, BLANK_CHAR};
            end
            scrolls++;
        endfunction

        function void apply_char(logic [7:0] code);
            if (code == CH_CR) begin
                col = 0;
            end else if (code == CH_LF) begin
                col = 0;
                row++;
            end else if (code == CH_BS) begin
                if (col != 0) col--;
            end else if (code == CH_TAB) begin
                col = (col / TAB_STOP + 1) * TAB_STOP;
            end else if (code >= PRINT_LO && code <= PRINT_HI) begin
                cells[row * COLUMNS + col] = {color, code};
                col++;
            end
            // wrap first, then scroll if the wrap or a line feed ran off the bottom
            if (col >= COLUMNS) begin
                col = 0;
                row++;
            end
            if (row >= ROWS) begin
                scroll_screen();
                row = ROWS - 1;
            end
        endfunction

        function void note_item(logic f, logic [7:0] code, logic [ROW_W-1:0] rr,
                                logic [COL_W-1:0] rc);
            cursor_report_t rep;
            rep.ch   = 8'h00;
            rep.attr = 8'h00;
            if (f == FUNC_PUT) begin
                apply_char(code);
                puts++;
            end else begin
                reads++;
                if (rr < ROWS && rc < COLUMNS) begin
                    rep.ch   = cells[int'(rr) * COLUMNS + int'(rc)][7:0];
                    rep.attr = cells[int'(rr) * COLUMNS + int'(rc)][15:8];
                end
            end
            rep.row = ROW_W'(row);
            rep.col = COL_W'(col);
            rep.loc = LOC_W'(row * COLUMNS + col);
            awaited.push_back(rep);
        endfunction

        task report(input string msg);
            if (errors < MAX_PRINTS) $display("[%0t] %s", $time, msg);
            errors++;
        endtask

        task check_result(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
                          input logic [LOC_W-1:0] loc, input logic [7:0] ch,
                          input logic [7:0] attr);
            cursor_report_t want;
            if (awaited.size() == 0) begin
                report($sformatf("unexpected item: row %0d col %0d char %h", r, c, ch));
                return;
            end
            want = awaited.pop_front();
            checked++;
            if (r !== want.row)
                report($sformatf("item %0d cursor_row %0d, want %0d", checked, r, want.row));
            if (c !== want.col)
                report($sformatf("item %0d cursor_col %0d, want %0d", checked, c, want.col));
            if (loc !== want.loc)
                report($sformatf("item %0d cursor_location %0d, want %0d",
                                 checked, loc, want.loc));
            if (ch !== want.ch)
                report($sformatf("item %0d cell_char %h, want %h", checked, ch, want.ch));
            if (attr !== want.attr)
                report($sformatf("item %0d cell_color %h, want %h", checked, attr, want.attr));
        endtask
    endclass

    logic                aclk;
    logic                aresetn     = 1'b0;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [7:0]          cfg_data    = 8'h00;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    logic                s_func      = FUNC_PUT;
    logic [7:0]          s_char_code = 8'h00;
    logic [ROW_W-1:0]    s_read_row  = '0;
    logic [COL_W-1:0]    s_read_col  = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    logic [ROW_W-1:0]    m_cursor_row;
    logic [COL_W-1:0]    m_cursor_col;
    logic [LOC_W-1:0]    m_cursor_location;
    logic [7:0]          m_cell_char;
    logic [7:0]          m_cell_color;

    screen_scoreboard sb = new();
    bit               send_steady = 1'b0;
    bit               take_steady = 1'b0;
    int               cycle_count = 0;
    int               colors_used = 1;

    text_terminal_char_engine_unit dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_func            (s_func),
        .s_char_code       (s_char_code),
        .s_read_row        (s_read_row),
        .s_read_col        (s_read_col),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_cursor_row      (m_cursor_row),
        .m_cursor_col      (m_cursor_col),
        .m_cursor_location (m_cursor_location),
        .m_cell_char       (m_cell_char),
        .m_cell_color      (m_cell_color)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic send_item(input logic f, input logic [7:0] code,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_func      <= f;
        s_char_code <= code;
        s_read_row  <= rr;
        s_read_col  <= rc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(f, code, rr, rc);
    endtask

    // Mostly text-like traffic, with cell reads (some on the cursor row) and some raw noise.
    task automatic send_random_item();
        int               pick;
        logic             f;
        logic [7:0]       code;
        logic [ROW_W-1:0] rr;
        logic [COL_W-1:0] rc;
        pick = $urandom_range(0, 99);
        f    = FUNC_PUT;
        code = 8'($urandom_range(PRINT_LO, PRINT_HI));
        rr   = ROW_W'($urandom);
        rc   = COL_W'($urandom);
        if (pick < 8) begin
            code = CH_LF;
        end else if (pick < 11) begin
            code = CH_CR;
        end else if (pick < 15) begin
            code = CH_TAB;
        end else if (pick < 19) begin
            code = CH_BS;
        end else if (pick < 25) begin
            code = 8'($urandom);
        end else if (pick < 38) begin
            f  = FUNC_READ;
            rr = pick[0] ? ROW_W'(sb.row) : ROW_W'($urandom_range(0, ROWS - 1));
            rc = COL_W'($urandom_range(0, COLUMNS - 1));
        end else if (pick < 42) begin
            f = FUNC_READ;
        end
        send_item(f, code, rr, rc);
    endtask

    task automatic write_color(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        sb.color = value;
        colors_used++;
    endtask

    // Hold until every result is in; a scroll keeps blanking after its item leaves.
    task automatic settle();
        while (sb.awaited.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int stall;
        forever begin
            if ((sb.checked % 64) == 0) take_steady = ($urandom_range(0, 3) == 0);
            stall = take_steady ? 0 : $urandom_range(0, 7);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (m_valid !== 1'b1) @(posedge aclk);
            sb.check_result(m_cursor_row, m_cursor_col, m_cursor_location,
                            m_cell_char, m_cell_color);
        end
    end

    initial begin
        logic [7:0] phase_color [PHASES];
        phase_color[0] = RESET_COLOR;
        phase_color[1] = 8'h00;
        phase_color[2] = 8'hFF;
        phase_color[3] = 8'($urandom);
        phase_color[4] = 8'($urandom);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // corners, out-of-range reads, every control byte, ignored bytes
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd0);
        send_item(FUNC_READ, 8'hFF, 5'(ROWS - 1), 7'(COLUMNS - 1));
        send_item(FUNC_READ, 8'h00, 5'(ROWS), 7'd0);
        send_item(FUNC_READ, 8'h00, 5'd0, 7'(COLUMNS));
        send_item(FUNC_READ, 8'h00, 5'h1F, 7'h7F);
        send_item(FUNC_PUT, CH_BS, 5'h1F, 7'h7F);
        send_item(FUNC_PUT, 8'h00, 5'd0, 7'd0);
        send_item(FUNC_PUT, 8'h80, 5'd0, 7'd0);
        send_item(FUNC_PUT, 8'hFF, 5'd0, 7'd0);
        send_item(FUNC_PUT, PRINT_LO, 5'd0, 7'd0);
        send_item(FUNC_PUT, PRINT_HI, 5'd0, 7'd0);
        send_item(FUNC_PUT, CH_BS, 5'd0, 7'd0);
        send_item(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
        send_item(FUNC_PUT, CH_CR, 5'd0, 7'd0);
        send_item(FUNC_PUT, CH_LF, 5'd0, 7'd0);
        send_item(FUNC_PUT, 8'h41, 5'd0, 7'd0);
        // tab repeatedly toward the right edge, stopping short of a wrap
        repeat (9) send_item(FUNC_PUT, CH_TAB, 5'd0, 7'd0);
        send_item(FUNC_READ, 8'h00, 5'd0, 7'd1);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                s_valid <= 1'b0;
                settle();
                write_color(phase_color[p]);
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if ((n % 64) == 0) send_steady = ($urandom_range(0, 3) == 0);
                send_random_item();
            end
        end
        s_valid <= 1'b0;
        settle();

        if (sb.awaited.size() != 0) begin
            sb.report($sformatf("%0d expected items never arrived", sb.awaited.size()));
        end
        $display("Drove %0d puts and %0d cell reads under %0d text colors, %0d scrolls.",
                 sb.puts, sb.reads, colors_used, sb.scrolls);
        $display("Compared %0d results, %0d mismatches.", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/ttce_pkg.sv
hw/rtl/ttce_front.sv
hw/rtl/ttce_fifo.sv
hw/rtl/ttce_back.sv
hw/rtl/text_terminal_char_engine_unit.sv
sim/testbench.sv
